[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the greyscale quantiser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that a property holds at every rising clock edge outside reset.
`define RGQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define RGQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RGQ_ASSERT(lbl, clk, rst, prop, msg)
`define RGQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/rgq_pkg.sv]
// Types, constants and helper functions of the greyscale quantiser.
package rgq_pkg;

  // Grey conversion modes held in the mode register.
  typedef enum logic [1:0] {
    MODE_MEAN   = 2'd0,
    MODE_MAX    = 2'd1,
    MODE_RMS    = 2'd2,
    MODE_POSTER = 2'd3
  } grey_mode_t;

  // Configuration register indexes.
  localparam logic CFG_IDX_MODE   = 1'b0;
  localparam logic CFG_IDX_SHADES = 1'b1;

  // Reset values: mean mode, 255 shades (a step of one).
  localparam grey_mode_t MODE_RESET = MODE_MEAN;
  localparam logic [7:0] STEP_RESET = 8'd1;
  localparam logic [7:0] GREY_MAX   = 8'd255;

  // Division by three as a multiplication by a reciprocal and a shift.
  // Exact for sums up to 765 and sums of squares up to 195075.
  localparam int         MEAN_SHIFT = 11;
  localparam logic [9:0] MEAN_RECIP = 10'd683;
  localparam int         MSQ_SHIFT  = 19;
  localparam logic [17:0] MSQ_RECIP = 18'd174763;

  // Number of two-digit stages in the root and quotient pipeline.
  localparam int MID_STAGES = 4;

  // First stage: channel sum, maximum and sum of squares.
  typedef struct packed {
    logic [9:0]  sum;
    logic [7:0]  maxv;
    logic [17:0] sqsum;
  } s1_t;

  // Second stage: mean and mean of the squares.
  typedef struct packed {
    logic [7:0]  mean;
    logic [7:0]  maxv;
    logic [15:0] msq;
  } s2_t;

  // Middle stages: square root and posterize quotient, worked digit by digit.
  typedef struct packed {
    logic [15:0] msq;
    logic [9:0]  sq_rem;
    logic [7:0]  root;
    logic [9:0]  num;
    logic [8:0]  dv_rem;
    logic [7:0]  quo;
    logic [7:0]  mean;
    logic [7:0]  maxv;
  } mid_t;

  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sq_t;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] quo;
  } dv_t;

  // One digit of the restoring square root: brings in two bits of the radicand.
  function automatic sq_t sqrt_step(input logic [9:0] rem, input logic [7:0] root,
                                    input logic [1:0] pair);
    logic [11:0] cur;
    logic [11:0] trial;
    sq_t         res;
    cur   = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (cur >= trial) begin
      res.rem  = 10'(cur - trial);
      res.root = {root[6:0], 1'b1};
    end else begin
      res.rem  = cur[9:0];
      res.root = {root[6:0], 1'b0};
    end
    return res;
  endfunction

  // One bit of the restoring division: brings in one bit of the dividend.
  function automatic dv_t div_step(input logic [8:0] rem, input logic [7:0] quo,
                                   input logic nb, input logic [8:0] dsr);
    logic [9:0] cur;
    dv_t        res;
    cur = {rem, nb};
    if (cur >= {1'b0, dsr}) begin
      res.rem = 9'(cur - {1'b0, dsr});
      res.quo = {quo[6:0], 1'b1};
    end else begin
      res.rem = cur[8:0];
      res.quo = {quo[6:0], 1'b0};
    end
    return res;
  endfunction

  // Posterize step floor(255 / (shades - 1)); fewer than two shades count as two.
  function automatic logic [7:0] step_of(input logic [7:0] shades);
    logic [7:0] d;
    logic [7:0] q;
    d = (shades < 8'd2) ? 8'd1 : 8'(shades - 8'd1);
    case (d) inside
      8'd1:            q = 8'd255;
      8'd2:            q = 8'd127;
      8'd3:            q = 8'd85;
      8'd4:            q = 8'd63;
      8'd5:            q = 8'd51;
      8'd6:            q = 8'd42;
      8'd7:            q = 8'd36;
      8'd8:            q = 8'd31;
      8'd9:            q = 8'd28;
      8'd10:           q = 8'd25;
      8'd11:           q = 8'd23;
      8'd12:           q = 8'd21;
      8'd13:           q = 8'd19;
      8'd14:           q = 8'd18;
      8'd15:           q = 8'd17;
      [8'd16:8'd17]:   q = 8'd15;
      8'd18:           q = 8'd14;
      8'd19:           q = 8'd13;
      [8'd20:8'd21]:   q = 8'd12;
      [8'd22:8'd23]:   q = 8'd11;
      [8'd24:8'd25]:   q = 8'd10;
      [8'd26:8'd28]:   q = 8'd9;
      [8'd29:8'd31]:   q = 8'd8;
      [8'd32:8'd36]:   q = 8'd7;
      [8'd37:8'd42]:   q = 8'd6;
      [8'd43:8'd51]:   q = 8'd5;
      [8'd52:8'd63]:   q = 8'd4;
      [8'd64:8'd85]:   q = 8'd3;
      [8'd86:8'd127]:  q = 8'd2;
      default:         q = 8'd1;
    endcase
    return q;
  endfunction

endpackage

[rtl/core/rgq_if.sv]
// Valid/ready channel interfaces for pixels in and grey levels out.
interface rgq_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgq_grey_if;
  logic       valid;
  logic       ready;
  logic [7:0] grey;

  modport source (output valid, output grey, input ready);
  modport sink   (input valid, input grey, output ready);
endinterface

[rtl/core/rgb_greyscale_quantizer_unit.sv]
// Pixel to grey level converter with mean, maximum, RMS and posterize modes.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+------------
//  pix     | in        | red, green, blue     | valid/ready
//  gry     | out       | grey                 | valid/ready
//  cfg     | in        | wr_index, wr_data    | wr_en only
//
// One pixel per clock while gry takes its results; a result reaches gry through seven register stages,
// four of them set by the eight root and quotient digits.
// Reset (rst, synchronous) empties the pipeline and restores mean mode and 255 shades.
// Each stage holds while the one after it is full and stalled; a bubble is closed up,
// so a pixel is taken while a finished result still waits on gry.
`include "assert_macros.svh"

module rgb_greyscale_quantizer_unit
  import rgq_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic           wr_index,
  input  logic [7:0]     wr_data,
  rgq_pixel_if.sink      pix,
  rgq_grey_if.source     gry
);

  // Configuration: the mode and the posterize step derived from the shade count.
  grey_mode_t grey_mode;
  logic [7:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_mode <= MODE_RESET;
      step      <= STEP_RESET;
    end else if (wr_en) begin
      if (wr_index == CFG_IDX_MODE) begin
        grey_mode <= grey_mode_t'(wr_data[1:0]);
      end else if (wr_index == CFG_IDX_SHADES) begin
        step <= step_of(wr_data);
      end
    end
  end

  // Stage registers and their valid bits.
  s1_t  s1;
  s2_t  s2;
  mid_t mid_q [MID_STAGES];
  logic s1_v, s2_v, out_v;
  logic [MID_STAGES-1:0] mid_v;
  logic [MID_STAGES-1:0] mid_adv;
  logic s1_adv, s2_adv, out_adv;
  logic [7:0] grey_q;

  // A stage loads when it is empty or the stage after it moves on.
  assign out_adv   = !out_v || gry.ready;
  assign s2_adv    = !s2_v || mid_adv[0];
  assign s1_adv    = !s1_v || s2_adv;
  assign pix.ready = s1_adv;

  // Stage one: sum, maximum and sum of squares.
  s1_t s1_next;
  always_comb begin
    logic [7:0] mx;
    mx = pix.red;
    if (pix.green > mx) begin
      mx = pix.green;
    end
    if (pix.blue > mx) begin
      mx = pix.blue;
    end
    s1_next.sum   = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
    s1_next.maxv  = mx;
    s1_next.sqsum = 18'(16'(pix.red) * 16'(pix.red)) + 18'(16'(pix.green) * 16'(pix.green))
                  + 18'(16'(pix.blue) * 16'(pix.blue));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_adv) begin
      s1_v <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1 <= s1_next;
    end
  end

  // Stage two: both divisions by three through reciprocal products.
  logic [19:0] mean_prod;
  logic [35:0] msq_prod;
  assign mean_prod = 20'(s1.sum) * 20'(MEAN_RECIP);
  assign msq_prod  = 36'(s1.sqsum) * 36'(MSQ_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2.mean <= mean_prod[MEAN_SHIFT +: 8];
      s2.maxv <= s1.maxv;
      s2.msq  <= msq_prod[MSQ_SHIFT +: 16];
    end
  end

  // Seed of the digit stages: empty root, dividend 2*mean + step.
  mid_t mid_init;
  always_comb begin
    mid_init.msq    = s2.msq;
    mid_init.sq_rem = '0;
    mid_init.root   = '0;
    mid_init.num    = 10'({s2.mean, 1'b0}) + 10'(step);
    mid_init.dv_rem = 9'(mid_init.num[9:8]);
    mid_init.quo    = '0;
    mid_init.mean   = s2.mean;
    mid_init.maxv   = s2.maxv;
  end

  logic [8:0] dsr;
  assign dsr = {step, 1'b0};

  // Digit stages: two root digits and two quotient bits in each.
  genvar j;
  for (j = 0; j < MID_STAGES; j++) begin : g_mid
    localparam int HI = 7 - 2 * j;
    localparam int LO = 6 - 2 * j;
    mid_t src;
    mid_t nxt;
    logic src_v;

    if (j == 0) begin : g_first
      assign src   = mid_init;
      assign src_v = s2_v;
    end else begin : g_rest
      assign src   = mid_q[j-1];
      assign src_v = mid_v[j-1];
    end

    if (j == MID_STAGES - 1) begin : g_last
      assign mid_adv[j] = !mid_v[j] || out_adv;
    end else begin : g_inner
      assign mid_adv[j] = !mid_v[j] || mid_adv[j+1];
    end

    always_comb begin
      sq_t sa, sb;
      dv_t da, db;
      sa = sqrt_step(src.sq_rem, src.root, src.msq[2*HI+1 -: 2]);
      sb = sqrt_step(sa.rem, sa.root, src.msq[2*LO+1 -: 2]);
      da = div_step(src.dv_rem, src.quo, src.num[HI], dsr);
      db = div_step(da.rem, da.quo, src.num[LO], dsr);
      nxt        = src;
      nxt.sq_rem = sb.rem;
      nxt.root   = sb.root;
      nxt.dv_rem = db.rem;
      nxt.quo    = db.quo;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mid_v[j] <= 1'b0;
      end else if (mid_adv[j]) begin
        mid_v[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (mid_adv[j]) begin
        mid_q[j] <= nxt;
      end
    end
  end

  // Output stage: mode selection and saturation of the posterized level.
  mid_t       fin;
  logic [15:0] post_prod;
  logic [7:0]  grey_next;
  assign fin       = mid_q[MID_STAGES-1];
  assign post_prod = 16'(fin.quo) * 16'(step);

  always_comb begin
    case (grey_mode)
      MODE_MEAN:   grey_next = fin.mean;
      MODE_MAX:    grey_next = fin.maxv;
      MODE_RMS:    grey_next = fin.root;
      MODE_POSTER: grey_next = (post_prod > 16'(GREY_MAX)) ? GREY_MAX : post_prod[7:0];
      default:     grey_next = fin.mean;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_adv) begin
      out_v <= mid_v[MID_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      grey_q <= grey_next;
    end
  end

  assign gry.valid = out_v;
  assign gry.grey  = grey_q;

  // Root bounds and valid bit of the last digit stage, for the checks below.
  logic        fin_v;
  logic [15:0] root_sq;
  logic [16:0] root_up;
  assign fin_v   = mid_v[MID_STAGES-1];
  assign root_sq = 16'(fin.root) * 16'(fin.root);
  assign root_up = 17'(fin.root) + 17'd1;

  // Assertions on the pipeline and the digit units.
  `RGQ_ASSERT_NEXT(a_enter, clk, rst, pix.valid && pix.ready, s1_v, "pixel lost at stage one")
  `RGQ_ASSERT(a_root_low, clk, rst, !fin_v || (root_sq <= fin.msq), "root too large")
  `RGQ_ASSERT(a_root_high, clk, rst, !fin_v || (root_up * root_up > 17'(fin.msq)), "root too small")
  `RGQ_ASSERT(a_div_rem, clk, rst, !fin_v || (fin.dv_rem < dsr), "quotient remainder too large")
  `RGQ_ASSERT_NEXT(a_hold, clk, rst, fin_v && !out_adv, fin_v && $stable(fin), "last stage moved")

endmodule

[tb/rgb_greyscale_quantizer_unit_tb.sv]
// Self-checking testbench for the pixel to grey level converter.
`timescale 1ns / 1ps

module rgb_greyscale_quantizer_unit_tb
  import rgq_pkg::*;
();

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Configuration port.
  logic       wr_en    = 1'b0;
  logic       wr_index = 1'b0;
  logic [7:0] wr_data  = 8'd0;

  // Channel signals driven by the testbench, known from time zero.
  logic       px_valid = 1'b0;
  logic [7:0] px_red   = 8'd0;
  logic [7:0] px_green = 8'd0;
  logic [7:0] px_blue  = 8'd0;
  logic       gy_ready = 1'b0;

  rgq_pixel_if pix_ch ();
  rgq_grey_if  gry_ch ();

  assign pix_ch.valid = px_valid;
  assign pix_ch.red   = px_red;
  assign pix_ch.green = px_green;
  assign pix_ch.blue  = px_blue;
  assign gry_ch.ready = gy_ready;

  rgb_greyscale_quantizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix      (pix_ch),
    .gry      (gry_ch)
  );

  // Shadow copy of the configuration registers.
  grey_mode_t mode_shadow   = MODE_MEAN;
  logic [7:0] shades_shadow = 8'd255;

  // Pixels waiting to be offered and grey levels waiting to arrive.
  pixel_t     pixels_pending[$];
  logic [7:0] grey_expected_q[$];
  logic [7:0] grey_want;

  // Idling and hold-off controls.
  int   tx_idle_pct = 9;
  int   rx_idle_pct = 9;
  logic tx_pause    = 1'b0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   hold_left   = 0;
  int   hold_len    = 300;
  logic px_taken    = 1'b0;

  // Run statistics.
  int fail_count      = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int input_stalls    = 0;
  int settings_used   = 0;

  // Largest root whose square does not exceed the value, found bit by bit.
  function automatic logic [7:0] int_sqrt(input logic [15:0] v);
    logic [7:0]  root;
    logic [7:0]  cand;
    logic [15:0] sq;
    root = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      cand = root | (8'd1 << i);
      sq   = {8'd0, cand} * {8'd0, cand};
      if (sq <= v) begin
        root = cand;
      end
    end
    return root;
  endfunction

  // Expected grey level of one pixel under the given mode and shade count.
  function automatic logic [7:0] grey_of_pixel(input grey_mode_t mode,
                                               input logic [7:0] shades,
                                               input pixel_t px);
    logic [9:0]  sum;
    logic [7:0]  mean;
    logic [7:0]  maxv;
    logic [17:0] sqsum;
    logic [15:0] msq;
    int          shd;
    int          step;
    int          quot;
    int          level;
    sum   = 10'(px.red) + 10'(px.green) + 10'(px.blue);
    mean  = 8'(sum / 10'd3);
    maxv  = px.red;
    if (px.green > maxv) begin
      maxv = px.green;
    end
    if (px.blue > maxv) begin
      maxv = px.blue;
    end
    sqsum = 18'(px.red) * 18'(px.red) + 18'(px.green) * 18'(px.green)
          + 18'(px.blue) * 18'(px.blue);
    msq   = 16'(sqsum / 18'd3);
    case (mode)
      MODE_MEAN: begin
        return mean;
      end
      MODE_MAX: begin
        return maxv;
      end
      MODE_RMS: begin
        return int_sqrt(msq);
      end
      default: begin
        // Fewer than two shades behave as two; ties round upwards.
        shd   = (shades < 8'd2) ? 2 : int'(shades);
        step  = 255 / (shd - 1);
        quot  = (2 * int'(mean) + step) / (2 * step);
        level = quot * step;
        if (level > 255) begin
          level = 255;
        end
        return 8'(level);
      end
    endcase
  endfunction

  // Channel value biased towards the extremes.
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0: begin
        return 8'd0;
      end
      1: begin
        return 8'd255;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = rand_channel();
    px.green = rand_channel();
    px.blue  = rand_channel();
    // Some pixels are already grey.
    if ($urandom_range(0, 7) == 0) begin
      px.green = px.red;
      px.blue  = px.red;
    end
    return px;
  endfunction

  // Pixel driver: holds an offered pixel until its transfer.
  always @(negedge clk) begin
    if (rst) begin
      px_valid <= 1'b0;
    end else if (px_valid && !px_taken) begin
      px_valid <= 1'b1;
    end else if (pixels_pending.size() != 0 && !tx_pause
                 && $urandom_range(0, 99) >= tx_idle_pct) begin
      px_valid <= 1'b1;
      px_red   <= pixels_pending[0].red;
      px_green <= pixels_pending[0].green;
      px_blue  <= pixels_pending[0].blue;
    end else begin
      px_valid <= 1'b0;
    end
  end

  // Pixel transfers: predict the grey level of each pixel taken in.
  always @(posedge clk) begin
    px_taken = 1'b0;
    if (!rst && px_valid && pix_ch.ready) begin
      px_taken = 1'b1;
      grey_expected_q.insert(grey_expected_q.size(),
                             grey_of_pixel(mode_shadow, shades_shadow,
                                           {px_red, px_green, px_blue}));
      void'(pixels_pending.pop_front());
      pixels_sent++;
    end
    if (!rst && px_valid && !pix_ch.ready) begin
      input_stalls++;
    end
  end

  // Result receiver: random idling plus long hold-offs on request.
  always @(negedge clk) begin
    if (rst) begin
      gy_ready <= 1'b0;
    end else if (hold_left > 0) begin
      gy_ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      gy_ready    <= 1'b0;
      hold_served <= hold_asked;
      hold_left   <= hold_len;
    end else begin
      gy_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result monitor: each transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && gry_ch.valid && gy_ready) begin
      if (grey_expected_q.size() == 0) begin
        $error("grey: no result expected, actual %0d", gry_ch.grey);
        fail_count++;
      end else begin
        grey_want = grey_expected_q.pop_front();
        if (gry_ch.grey !== grey_want) begin
          $error("grey: expected %0d, actual %0d", grey_want, gry_ch.grey);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixels_pending.insert(pixels_pending.size(), pixel_t'({r, g, b}));
  endtask

  // Wait until every pixel has gone in and every result has come out.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pixels_pending.size() != 0 || grey_expected_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic [7:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    if (idx == CFG_IDX_MODE) begin
      mode_shadow = grey_mode_t'(data[1:0]);
    end else begin
      shades_shadow = data;
    end
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Change both registers once the block has gone quiet.
  task automatic apply_setting(input grey_mode_t mode, input logic [7:0] shades);
    wait_drained();
    program_reg(CFG_IDX_MODE, {6'($urandom_range(0, 63)), mode});
    program_reg(CFG_IDX_SHADES, shades);
    settings_used++;
  endtask

  // Stimulus sequence.
  initial begin
    int         base;
    grey_mode_t mode;
    logic [7:0] shades;
    logic [7:0] shade_picks[6];

    shade_picks = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd255};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: mean mode, flooring of the sum.
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd1, 8'd1, 8'd2);
    add_pixel(8'd255, 8'd254, 8'd254);

    // Maximum of each channel in turn.
    apply_setting(MODE_MAX, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd7, 8'd7, 8'd7);

    // Root mean square at the extremes.
    apply_setting(MODE_RMS, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd1, 8'd1, 8'd0);

    // Step of two: saturation at full white and a tie rounding up.
    apply_setting(MODE_POSTER, 8'd128);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd1, 8'd1, 8'd1);
    add_pixel(8'd0, 8'd0, 8'd0);

    // Shade counts below two act as two; counts of two, 255 and three follow.
    apply_setting(MODE_POSTER, 8'd0);
    add_pixel(8'd127, 8'd128, 8'd128);
    add_pixel(8'd128, 8'd128, 8'd128);
    apply_setting(MODE_POSTER, 8'd1);
    add_pixel(8'd200, 8'd200, 8'd200);
    apply_setting(MODE_POSTER, 8'd2);
    add_pixel(8'd127, 8'd127, 8'd128);
    add_pixel(8'd128, 8'd128, 8'd128);
    apply_setting(MODE_POSTER, 8'd255);
    add_pixel(8'd100, 8'd150, 8'd200);
    apply_setting(MODE_POSTER, 8'd3);
    add_pixel(8'd64, 8'd64, 8'd63);

    // Random phases, each with its own setting.
    for (int p = 0; p < 20; p++) begin
      mode = grey_mode_t'(p % 4);
      if ($urandom_range(0, 2) == 0) begin
        shades = shade_picks[$urandom_range(0, 5)];
      end else begin
        shades = 8'($urandom_range(0, 255));
      end
      apply_setting(mode, shades);
      tx_idle_pct = (p == 2) ? 0 : 9;
      rx_idle_pct = (p == 2) ? 0 : 9;
      for (int k = 0; k < 100; k++) begin
        pixels_pending.insert(pixels_pending.size(), rand_pixel());
      end
      if (p == 6) begin
        // Hold the output back so the pipeline fills and stalls its input.
        base = pixels_sent;
        do begin
          @(negedge clk);
        end while (pixels_sent < base + 10);
        hold_asked++;
      end
      if (p == 11) begin
        // Stop sending halfway until every result is back.
        do begin
          @(negedge clk);
        end while (pixels_pending.size() > 50);
        tx_pause = 1'b1;
        do begin
          @(negedge clk);
        end while (grey_expected_q.size() != 0);
        tx_pause = 1'b0;
      end
    end

    // Drain, with a bound, then let the pipeline run empty.
    do begin
      @(negedge clk);
    end while (pixels_pending.size() != 0);
    for (int c = 0; c < 2000 && grey_expected_q.size() != 0; c++) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (grey_expected_q.size() != 0) begin
      $error("grey: %0d results never arrived", grey_expected_q.size());
      fail_count++;
    end

    $display("Sent %0d pixels under %0d settings across all four modes, %0d results checked.",
             pixels_sent, settings_used, results_checked);
    $display("Input was held back for %0d cycles; %0d mismatches seen.",
             input_stalls, fail_count);
    if (fail_count == 0) begin
      $display("rgb_greyscale_quantizer_unit_tb: PASS");
    end else begin
      $display("rgb_greyscale_quantizer_unit_tb: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("rgb_greyscale_quantizer_unit_tb: FAIL");
    $finish;
  end

endmodule
